/* rtl/dbrc_pkg.sv */
package dbrc_pkg;

    // frame geometry
    localparam int CHANNEL_COUNT = 8;
    localparam int FRAME_LEN     = 6 + 2 * CHANNEL_COUNT;
    localparam int IDX_W         = $clog2(FRAME_LEN);

    localparam logic [IDX_W-1:0] IDX_SYNC0  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_SYNC1  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_SYNC2  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_SIZE   = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CMD    = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_CH0    = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

    localparam int CH_PITCH    = 1;
    localparam int CH_THROTTLE = 3;

    localparam logic [7:0] SYNC0_BYTE = 8'h24;  // '$'
    localparam logic [7:0] SYNC1_BYTE = 8'h4D;  // 'M'
    localparam logic [7:0] SYNC2_BYTE = 8'h3C;  // '<'
    localparam logic [7:0] SIZE_BYTE  = 8'(2 * CHANNEL_COUNT);
    localparam logic [7:0] CMD_SET_RAW_RC = 8'd200;

    // payload widths
    localparam int ECHO_W = 16;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HARD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE = 3'd5;

    // register reset values
    localparam logic [15:0] ALPHA_RST    = 16'd22938;
    localparam logic [9:0]  TRIGGER_RST  = 10'd10;
    localparam logic [9:0]  HARD_RST     = 10'd30;
    localparam logic [10:0] PLOW_RST     = 11'd1550;
    localparam logic [10:0] PHIGH_RST    = 11'd1800;
    localparam logic [10:0] THROTTLE_RST = 11'd1050;

    // RC and distance constants
    localparam logic [10:0] RC_LOW  = 11'd1000;
    localparam logic [10:0] RC_MID  = 11'd1500;
    localparam logic [10:0] RC_HIGH = 11'd2000;
    localparam logic [15:0] DIST_LIMIT = 16'd38400;
    localparam logic [15:0] DIST_RESET = 16'd25600;
    // ticks*64/116 == (ticks*16)/29 == (ticks*578525) >> 20, exact for 16-bit ticks
    localparam logic [35:0] TICK_RECIP = 36'd578525;
    localparam logic [35:0] ROUND_HALF = 36'd32768;

    // serial unit step counts
    localparam int CNT_W     = 5;
    localparam int MUL_STEPS = 17;
    localparam int DIV_STEPS = 27;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_MUL_A,
        S_MUL_B,
        S_PITCH,
        S_RAMP,
        S_MUL_P,
        S_ROUND,
        S_DIV_P,
        S_APPLY,
        S_SEND
    } state_t;

    function automatic logic [10:0] clamp_rc(input logic [11:0] v);
        logic [10:0] r;
        if (v < 12'(RC_LOW))
            r = RC_LOW;
        else if (v > 12'(RC_HIGH))
            r = RC_HIGH;
        else
            r = v[10:0];
        return r;
    endfunction

endpackage

/* rtl/dbrc_item_if.sv */
interface dbrc_item_if;
    logic                        valid;
    logic                        ready;
    logic [dbrc_pkg::ECHO_W-1:0] echo_ticks;
    logic                        timed_out;

    modport source (output valid, echo_ticks, timed_out, input ready);
    modport sink   (input valid, echo_ticks, timed_out, output ready);
endinterface

/* rtl/dbrc_frame_if.sv */
interface dbrc_frame_if;
    logic                        valid;
    logic                        ready;
    logic [dbrc_pkg::BYTE_W-1:0] frame_byte;
    logic                        last;

    modport source (output valid, frame_byte, last, input ready);
    modport sink   (input valid, frame_byte, last, output ready);
endinterface

/* rtl/distance_brake_rc_frame_encoder_core.sv */
// Each echo measurement accepted on item produces one 22-byte SET_RAW_RC frame
// on frame, one byte per transfer, last set on the checksum byte. Multiplies and
// the divide run through one shared 36-bit adder/subtractor: a 17-step reciprocal
// multiply turns ticks into 1/64 cm, two 17-step shift-add multiplies update the
// low-pass filter, and while braking a 17-step multiply plus a 27-step divide give
// the pitch ramp. The next item is taken only once the frame's last byte has been
// loaded and the sequencer is idle again, with the frame bytes leaving one per cycle
// while the sink is ready; the last byte may still wait in the output register while
// the next item is taken. item.ready is high only while the sequencer is idle.
module distance_brake_rc_frame_encoder_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    dbrc_item_if.sink                             item,
    dbrc_frame_if.source                          frame,
    input  logic                                  cfg_we,
    input  logic [dbrc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dbrc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    // configuration
    logic [15:0] alpha_reg;
    logic [9:0]  trig_reg;
    logic [9:0]  hard_reg;
    logic [10:0] plow_reg;
    logic [10:0] phigh_reg;
    logic [10:0] thr_reg;

    // control
    dbrc_pkg::state_t state_reg, state_next;
    logic [dbrc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [dbrc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    logic [15:0] filt_reg, filt_next;

    // datapath
    logic        upd_ok_reg, upd_ok_next;
    logic [35:0] acc_reg, acc_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [16:0] mlt_reg, mlt_next;
    logic [35:0] mcd_reg, mcd_next;
    logic [15:0] num_reg, num_next;
    logic [15:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [10:0] pitch_reg, pitch_next;
    logic [7:0]  csum_reg, csum_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;

    // shared unit
    logic [35:0] add_a, add_b, add_sum;
    logic        add_sub;
    logic        div_mode;
    logic        qbit;
    logic [16:0] div_t;
    logic [15:0] echo_dist;
    logic        dist_upd;
    logic [15:0] trig64;
    logic [10:0] span;
    logic [9:0]  span_c;
    logic [11:0] diff;
    logic [10:0] diff_mag;
    logic [11:0] ramp_val;
    logic        load;
    logic [7:0]  cur_byte;
    logic [dbrc_pkg::IDX_W-1:0] ch_off;
    logic [10:0] ch_val;

    assign item.ready       = (state_reg == dbrc_pkg::S_IDLE);
    assign frame.valid      = ovalid_reg;
    assign frame.frame_byte = obyte_reg;
    assign frame.last       = olast_reg;

    // shared adder/subtractor and decision terms
    always_comb
    begin
        div_mode = (state_reg == dbrc_pkg::S_DIV_P);
        div_t    = {rem_reg, acc_reg[26]};
        if (div_mode)
        begin
            add_a   = 36'(div_t);
            add_b   = 36'(dsr_reg);
            add_sub = 1'b1;
        end
        else if (state_reg == dbrc_pkg::S_ROUND)
        begin
            add_a   = acc_reg;
            add_b   = neg_reg ? 36'(den_reg - 16'd1) : '0;
            add_sub = 1'b0;
        end
        else
        begin
            add_a   = acc_reg;
            add_b   = mlt_reg[0] ? mcd_reg : '0;
            add_sub = 1'b0;
        end
        add_sum  = add_a + (add_sub ? ~add_b : add_b) + 36'(add_sub);
        qbit     = ~add_sum[35];   // no borrow: partial remainder >= divisor
        // reciprocal product scaled by 2^20 gives floor(ticks*16/29)
        echo_dist = add_sum[35:20];
        dist_upd = upd_ok_reg && (echo_dist < dbrc_pkg::DIST_LIMIT);

        trig64   = {trig_reg, 6'b0};
        span     = {1'b0, trig_reg} - {1'b0, hard_reg};
        span_c   = (span[10] || span == 11'd0) ? 10'd1 : span[9:0];
        diff     = {1'b0, phigh_reg} - {1'b0, plow_reg};
        diff_mag = diff[11] ? 11'(-diff) : diff[10:0];
        ramp_val = neg_reg ? ({1'b0, plow_reg} - {1'b0, acc_reg[10:0]})
                           : ({1'b0, plow_reg} + {1'b0, acc_reg[10:0]});

        load     = !ovalid_reg || frame.ready;

        ch_off   = idx_reg - dbrc_pkg::IDX_CH0;
        if (ch_off[dbrc_pkg::IDX_W-1:1] == (dbrc_pkg::IDX_W-1)'(dbrc_pkg::CH_PITCH))
            ch_val = pitch_reg;
        else if (ch_off[dbrc_pkg::IDX_W-1:1] == (dbrc_pkg::IDX_W-1)'(dbrc_pkg::CH_THROTTLE))
            ch_val = thr_reg;
        else
            ch_val = dbrc_pkg::RC_MID;

        priority if (idx_reg == dbrc_pkg::IDX_SYNC0)
            cur_byte = dbrc_pkg::SYNC0_BYTE;
        else if (idx_reg == dbrc_pkg::IDX_SYNC1)
            cur_byte = dbrc_pkg::SYNC1_BYTE;
        else if (idx_reg == dbrc_pkg::IDX_SYNC2)
            cur_byte = dbrc_pkg::SYNC2_BYTE;
        else if (idx_reg == dbrc_pkg::IDX_SIZE)
            cur_byte = dbrc_pkg::SIZE_BYTE;
        else if (idx_reg == dbrc_pkg::IDX_CMD)
            cur_byte = dbrc_pkg::CMD_SET_RAW_RC;
        else if (idx_reg == dbrc_pkg::IDX_LAST)
            cur_byte = csum_reg;
        else
            cur_byte = ch_off[0] ? {5'b0, ch_val[10:8]} : ch_val[7:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbrc_pkg::S_IDLE:
                if (item.valid)
                    state_next = dbrc_pkg::S_DIST;
            dbrc_pkg::S_DIST:
                if (cnt_reg == dbrc_pkg::MUL_LAST)
                    state_next = dist_upd ? dbrc_pkg::S_MUL_A : dbrc_pkg::S_PITCH;
            dbrc_pkg::S_MUL_A:
                if (cnt_reg == dbrc_pkg::MUL_LAST)
                    state_next = dbrc_pkg::S_MUL_B;
            dbrc_pkg::S_MUL_B:
                if (cnt_reg == dbrc_pkg::MUL_LAST)
                    state_next = dbrc_pkg::S_PITCH;
            dbrc_pkg::S_PITCH:
                state_next = (filt_reg >= trig64) ? dbrc_pkg::S_SEND : dbrc_pkg::S_RAMP;
            dbrc_pkg::S_RAMP:
                state_next = (num_reg >= den_reg) ? dbrc_pkg::S_SEND : dbrc_pkg::S_MUL_P;
            dbrc_pkg::S_MUL_P:
                if (cnt_reg == dbrc_pkg::MUL_LAST)
                    state_next = dbrc_pkg::S_ROUND;
            dbrc_pkg::S_ROUND:
                state_next = dbrc_pkg::S_DIV_P;
            dbrc_pkg::S_DIV_P:
                if (cnt_reg == dbrc_pkg::DIV_LAST)
                    state_next = dbrc_pkg::S_APPLY;
            dbrc_pkg::S_APPLY:
                state_next = dbrc_pkg::S_SEND;
            dbrc_pkg::S_SEND:
                if (load && idx_reg == dbrc_pkg::IDX_LAST)
                    state_next = dbrc_pkg::S_IDLE;
            default:
                state_next = dbrc_pkg::S_IDLE;
        endcase
    end

    // datapath and output register control
    always_comb
    begin
        cnt_next    = cnt_reg + dbrc_pkg::CNT_W'(1);
        idx_next    = idx_reg;
        filt_next   = filt_reg;
        upd_ok_next = upd_ok_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        mlt_next    = mlt_reg >> 1;
        mcd_next    = mcd_reg << 1;
        num_next    = num_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        pitch_next  = pitch_reg;
        csum_next   = csum_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !frame.ready;

        unique case (state_reg)
            dbrc_pkg::S_IDLE:
            begin
                cnt_next    = '0;
                upd_ok_next = !item.timed_out && (item.echo_ticks != '0);
                acc_next    = '0;
                mlt_next    = 17'(item.echo_ticks);
                mcd_next    = dbrc_pkg::TICK_RECIP;
            end
            dbrc_pkg::S_DIST:
            begin
                acc_next = add_sum;
                if (cnt_reg == dbrc_pkg::MUL_LAST)
                begin
                    cnt_next = '0;
                    acc_next = dbrc_pkg::ROUND_HALF;
                    mlt_next = 17'(alpha_reg);
                    mcd_next = 36'(echo_dist);
                end
            end
            dbrc_pkg::S_DIV_P:
            begin
                rem_next = qbit ? add_sum[15:0] : div_t[15:0];
                acc_next = {9'b0, acc_reg[25:0], qbit};
            end
            dbrc_pkg::S_MUL_A:
            begin
                acc_next = add_sum;
                if (cnt_reg == dbrc_pkg::MUL_LAST)
                begin
                    cnt_next = '0;
                    mlt_next = 17'h10000 - 17'(alpha_reg);
                    mcd_next = 36'(filt_reg);
                end
            end
            dbrc_pkg::S_MUL_B:
            begin
                acc_next = add_sum;
                if (cnt_reg == dbrc_pkg::MUL_LAST)
                    filt_next = add_sum[31:16];
            end
            dbrc_pkg::S_PITCH:
            begin
                pitch_next = dbrc_pkg::RC_MID;
                num_next   = trig64 - filt_reg;
                den_next   = {span_c, 6'b0};
                neg_next   = diff[11];
                idx_next   = '0;
                csum_next  = '0;
            end
            dbrc_pkg::S_RAMP:
            begin
                pitch_next = dbrc_pkg::clamp_rc({1'b0, phigh_reg});
                cnt_next   = '0;
                acc_next   = '0;
                mlt_next   = 17'(diff_mag);
                mcd_next   = 36'(num_reg);
            end
            dbrc_pkg::S_MUL_P:
                acc_next = add_sum;
            dbrc_pkg::S_ROUND:
            begin
                // ceiling for a downward ramp
                acc_next = add_sum;
                rem_next = '0;
                dsr_next = den_reg;
                cnt_next = '0;
            end
            dbrc_pkg::S_APPLY:
                pitch_next = dbrc_pkg::clamp_rc(ramp_val);
            dbrc_pkg::S_SEND:
            begin
                if (load)
                begin
                    obyte_next  = cur_byte;
                    olast_next  = (idx_reg == dbrc_pkg::IDX_LAST);
                    ovalid_next = 1'b1;
                    if (idx_reg >= dbrc_pkg::IDX_SIZE && idx_reg != dbrc_pkg::IDX_LAST)
                        csum_next = csum_reg ^ cur_byte;
                    idx_next = (idx_reg == dbrc_pkg::IDX_LAST) ? '0
                                                                : idx_reg + dbrc_pkg::IDX_W'(1);
                end
            end
            default:
                cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dbrc_pkg::S_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
            filt_reg   <= dbrc_pkg::DIST_RESET;
            alpha_reg  <= dbrc_pkg::ALPHA_RST;
            trig_reg   <= dbrc_pkg::TRIGGER_RST;
            hard_reg   <= dbrc_pkg::HARD_RST;
            plow_reg   <= dbrc_pkg::PLOW_RST;
            phigh_reg  <= dbrc_pkg::PHIGH_RST;
            thr_reg    <= dbrc_pkg::THROTTLE_RST;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
            filt_reg   <= filt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dbrc_pkg::REG_ALPHA:    alpha_reg <= cfg_wdata;
                    dbrc_pkg::REG_TRIGGER:  trig_reg  <= cfg_wdata[9:0];
                    dbrc_pkg::REG_HARD:     hard_reg  <= cfg_wdata[9:0];
                    dbrc_pkg::REG_PLOW:     plow_reg  <= cfg_wdata[10:0];
                    dbrc_pkg::REG_PHIGH:    phigh_reg <= cfg_wdata[10:0];
                    dbrc_pkg::REG_THROTTLE: thr_reg   <= cfg_wdata[10:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        upd_ok_reg <= upd_ok_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        mlt_reg    <= mlt_next;
        mcd_reg    <= mcd_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        pitch_reg  <= pitch_next;
        csum_reg   <= csum_next;
        obyte_reg  <= obyte_next;
        olast_reg  <= olast_next;
    end

`ifndef SYNTH
    // filter only moves at the end of the second multiply
    a_filt_update: assert property (@(posedge clk) disable iff (!rst_n)
        (filt_reg != $past(filt_reg)) |-> ($past(state_reg) == dbrc_pkg::S_MUL_B))
        else $error("filtered distance changed outside the filter update");

    // byte counter wraps back to zero before the sequencer goes idle
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dbrc_pkg::S_IDLE) |-> (idx_reg == '0))
        else $error("frame byte index not cleared at idle");

    // restoring divide keeps its partial remainder below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dbrc_pkg::S_DIV_P) |-> (rem_reg < dsr_reg))
        else $error("divider remainder out of range");

    // a frame's last byte is loaded only as the sequencer returns to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(frame.valid && frame.last) && $past(state_reg) == dbrc_pkg::S_SEND)
        |-> (state_reg == dbrc_pkg::S_IDLE))
        else $error("last byte issued mid-frame");
`endif

endmodule
